// ----- rtl/lavm_pkg.sv -----
// Shared constants and transaction types for the look-at view matrix block.
package lavm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AW        = FRAC_BITS + 2;
    localparam int EW        = (FRAC_BITS + 4 > 32) ? FRAC_BITS + 4 : 32;
    localparam int VW        = (EW + 1 > 2 * AW + 1) ? EW + 1 : 2 * AW + 1;
    localparam int NW        = 30;
    localparam int NORM_MSB  = NW - 1;
    localparam int SQ_W      = 63;
    localparam int SQ_ST     = 16;
    localparam int LEN_W     = 32;
    localparam int QW        = FRAC_BITS + 2;
    localparam int NUM_W     = NW + FRAC_BITS + 1;
    localparam int UNIT_LAT  = SQ_ST + QW + 7;

    localparam logic signed [AW-1:0] ONE  = AW'(64'd1 << FRAC_BITS);
    localparam logic signed [AW-1:0] UP_X = AW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    typedef struct packed {
        logic               use_default;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] translation;
        logic               degenerate;
        logic               last_row;
    } t_row;

    typedef struct packed {
        logic               vld;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } t_uin;

    typedef struct packed {
        logic               vld;
        logic               ok;
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [AW-1:0] z;
    } t_uout;

endpackage

// ----- rtl/lavm_unit.sv -----
// Pipelined vector normalizer: range shift, sum of squares, square root, divide.
module lavm_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lavm_pkg::t_uin    i_vec,
    output lavm_pkg::t_uout   o_unit
);

    localparam int VW       = lavm_pkg::VW;
    localparam int AW       = lavm_pkg::AW;
    localparam int NW       = lavm_pkg::NW;
    localparam int NORM_MSB = lavm_pkg::NORM_MSB;
    localparam int SQ_W     = lavm_pkg::SQ_W;
    localparam int SQ_ST    = lavm_pkg::SQ_ST;
    localparam int LEN_W    = lavm_pkg::LEN_W;
    localparam int QW       = lavm_pkg::QW;
    localparam int NUM_W    = lavm_pkg::NUM_W;
    localparam int FB       = lavm_pkg::FRAC_BITS;
    localparam int MSB_W    = $clog2(VW);
    localparam int CW       = LEN_W + QW;

    logic            r1_vld;
    logic [VW-1:0]   r1_m [3];
    logic [2:0]      r1_sgn;
    logic [VW-1:0]   r1_mx;
    logic [VW-1:0]   n1_m [3];
    logic [2:0]      n1_sgn;
    logic [VW-1:0]   n1_mx;

    logic            r2_vld;
    logic [VW-1:0]   r2_m [3];
    logic [2:0]      r2_sgn;
    logic            r2_nz;
    logic [MSB_W-1:0] r2_msb;
    logic [MSB_W-1:0] n2_msb;

    logic            r3_vld;
    logic [NW-1:0]   r3_m [3];
    logic [2:0]      r3_sgn;
    logic            r3_ok;
    logic [NW-1:0]   n3_m [3];

    logic            r4_vld;
    logic [NW-1:0]   r4_m [3];
    logic [2*NW-1:0] r4_sq [3];
    logic [2:0]      r4_sgn;
    logic            r4_ok;

    logic            r_sv  [SQ_ST+1];
    logic            r_sok [SQ_ST+1];
    logic [2:0]      r_ss  [SQ_ST+1];
    logic [NW-1:0]   r_sm  [SQ_ST+1][3];
    logic [SQ_W-1:0] r_sn  [SQ_ST+1];
    logic [SQ_W-1:0] r_sr  [SQ_ST+1];
    logic [SQ_W-1:0] n_sn  [SQ_ST];
    logic [SQ_W-1:0] n_sr  [SQ_ST];

    logic            r_dv  [QW+1];
    logic            r_dok [QW+1];
    logic [2:0]      r_ds  [QW+1];
    logic [LEN_W-1:0] r_dl [QW+1];
    logic [NUM_W-1:0] r_dr [QW+1][3];
    logic [QW-1:0]   r_dq  [QW+1][3];
    logic [NUM_W-1:0] n_dr [QW][3];
    logic [QW-1:0]   n_dq  [QW][3];
    logic [LEN_W-1:0] w_len;

    lavm_pkg::t_uout r_out;
    lavm_pkg::t_uout n_out;

    always_comb begin
        n1_sgn  = {i_vec.z[VW-1], i_vec.y[VW-1], i_vec.x[VW-1]};
        n1_m[0] = n1_sgn[0] ? VW'(-i_vec.x) : VW'(i_vec.x);
        n1_m[1] = n1_sgn[1] ? VW'(-i_vec.y) : VW'(i_vec.y);
        n1_m[2] = n1_sgn[2] ? VW'(-i_vec.z) : VW'(i_vec.z);
        n1_mx   = n1_m[0];
        if (n1_m[1] > n1_mx) begin
            n1_mx = n1_m[1];
        end
        if (n1_m[2] > n1_mx) begin
            n1_mx = n1_m[2];
        end
    end

    always_comb begin
        n2_msb = '0;
        for (int i = 0; i < VW; i++) begin
            if (r1_mx[i]) begin
                n2_msb = MSB_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r2_msb >= MSB_W'(NORM_MSB)) begin
                n3_m[i] = NW'(r2_m[i] >> (r2_msb - MSB_W'(NORM_MSB)));
            end else begin
                n3_m[i] = NW'(r2_m[i] << (MSB_W'(NORM_MSB) - r2_msb));
            end
        end
    end

    always_comb begin
        logic [SQ_W-1:0] sn;
        logic [SQ_W-1:0] sr;
        logic [SQ_W-1:0] sb;
        for (int s = 0; s < SQ_ST; s++) begin
            sn = r_sn[s];
            sr = r_sr[s];
            for (int j = 0; j < 2; j++) begin
                sb = SQ_W'(1) << (SQ_W - 1 - 2 * (2 * s + j));
                if (sn >= sr + sb) begin
                    sn = sn - (sr + sb);
                    sr = (sr >> 1) + sb;
                end else begin
                    sr = sr >> 1;
                end
            end
            n_sn[s] = sn;
            n_sr[s] = sr;
        end
    end

    assign w_len = LEN_W'(r_sr[SQ_ST]);

    always_comb begin
        logic [CW-1:0] dv;
        for (int k = 0; k < QW; k++) begin
            dv = CW'(r_dl[k]) << (QW - 1 - k);
            for (int i = 0; i < 3; i++) begin
                if (CW'(r_dr[k][i]) >= dv) begin
                    n_dr[k][i] = NUM_W'(CW'(r_dr[k][i]) - dv);
                    n_dq[k][i] = r_dq[k][i] | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_dr[k][i] = r_dr[k][i];
                    n_dq[k][i] = r_dq[k][i];
                end
            end
        end
    end

    always_comb begin
        n_out.vld = r_dv[QW];
        n_out.ok  = r_dok[QW];
        n_out.x   = '0;
        n_out.y   = '0;
        n_out.z   = '0;
        if (r_dok[QW]) begin
            n_out.x = r_ds[QW][0] ? -AW'(r_dq[QW][0]) : AW'(r_dq[QW][0]);
            n_out.y = r_ds[QW][1] ? -AW'(r_dq[QW][1]) : AW'(r_dq[QW][1]);
            n_out.z = r_ds[QW][2] ? -AW'(r_dq[QW][2]) : AW'(r_dq[QW][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out.vld <= 1'b0;
            for (int s = 0; s <= SQ_ST; s++) begin
                r_sv[s] <= 1'b0;
            end
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r1_vld    <= i_vec.vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r_sv[0]   <= r4_vld;
            for (int s = 0; s < SQ_ST; s++) begin
                r_sv[s+1] <= r_sv[s];
            end
            r_dv[0]   <= r_sv[SQ_ST];
            for (int k = 0; k < QW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_out     <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m   <= n1_m;
        r1_sgn <= n1_sgn;
        r1_mx  <= n1_mx;

        r2_m   <= r1_m;
        r2_sgn <= r1_sgn;
        r2_nz  <= |r1_mx;
        r2_msb <= n2_msb;

        r3_m   <= n3_m;
        r3_sgn <= r2_sgn;
        r3_ok  <= r2_nz;

        r4_m   <= r3_m;
        r4_sgn <= r3_sgn;
        r4_ok  <= r3_ok;
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= (2*NW)'(r3_m[i]) * (2*NW)'(r3_m[i]);
        end

        r_sn[0]  <= SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
        r_sr[0]  <= '0;
        r_sm[0]  <= r4_m;
        r_ss[0]  <= r4_sgn;
        r_sok[0] <= r4_ok;
        for (int s = 0; s < SQ_ST; s++) begin
            r_sn[s+1]  <= n_sn[s];
            r_sr[s+1]  <= n_sr[s];
            r_sm[s+1]  <= r_sm[s];
            r_ss[s+1]  <= r_ss[s];
            r_sok[s+1] <= r_sok[s];
        end

        r_dl[0]  <= w_len;
        r_ds[0]  <= r_ss[SQ_ST];
        r_dok[0] <= r_sok[SQ_ST];
        for (int i = 0; i < 3; i++) begin
            r_dr[0][i] <= (NUM_W'(r_sm[SQ_ST][i]) << FB) + NUM_W'(w_len >> 1);
            r_dq[0][i] <= '0;
        end
        for (int k = 0; k < QW; k++) begin
            r_dl[k+1]  <= r_dl[k];
            r_ds[k+1]  <= r_ds[k];
            r_dok[k+1] <= r_dok[k];
            r_dr[k+1]  <= n_dr[k];
            r_dq[k+1]  <= n_dq[k];
        end
    end

    assign o_unit = r_out;

endmodule

// ----- rtl/look_at_view_matrix_top.sv -----
// Left-handed look-at view matrix: one transaction in, three rows out, all values with
// 16 fraction bits. A transaction is taken when start is high and busy is low; busy then
// stays high while r_gap counts down to zero. A new transaction can enter before earlier
// ones have left the pipeline, and the block never stalls. The three rows (right, up,
// forward) come out on consecutive cycles, each marked by o_result_valid for one cycle.
// The forward, right and up axes come from three chained normalizers, each a pipelined
// square root of two steps a stage followed by a one-bit-per-stage divider. The receiver
// cannot hold rows off.
module look_at_view_matrix_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  lavm_pkg::t_cmd   i_cmd,
    output logic             o_result_valid,
    output lavm_pkg::t_row   o_result
);

    localparam int FB  = lavm_pkg::FRAC_BITS;
    localparam int AW  = lavm_pkg::AW;
    localparam int EW  = lavm_pkg::EW;
    localparam int VW  = lavm_pkg::VW;
    localparam int LAT = lavm_pkg::UNIT_LAT;
    localparam int PW  = AW + EW;
    localparam int SW  = PW + 2;
    localparam logic signed [EW-1:0] EYE_DEF = EW'(64'd5 << FB);

    typedef struct packed {
        logic signed [EW-1:0] ex;
        logic signed [EW-1:0] ey;
        logic signed [EW-1:0] ez;
        logic signed [AW-1:0] fx;
        logic signed [AW-1:0] fy;
        logic signed [AW-1:0] fz;
        logic                 fok;
        logic signed [AW-1:0] rx;
        logic signed [AW-1:0] ry;
        logic signed [AW-1:0] rz;
        logic                 rok;
    } t_side;

    logic                 w_accept;
    logic [1:0]           r_gap;

    logic                 r_in_vld;
    logic signed [EW-1:0] r_eye [3];
    logic signed [VW-1:0] r_d   [3];
    logic signed [EW-1:0] n_eye [3];
    logic signed [VW-1:0] n_d   [3];

    lavm_pkg::t_uin       w_a_in;
    lavm_pkg::t_uin       w_b_in;
    lavm_pkg::t_uin       w_c_in;
    lavm_pkg::t_uout      w_a_out;
    lavm_pkg::t_uout      w_b_out;
    lavm_pkg::t_uout      w_c_out;

    t_side                r_dla [LAT];
    t_side                r_dlb [LAT];
    t_side                r_dlc [LAT];
    t_side                n_a_side;
    t_side                n_x1_side;
    t_side                n_y1_side;

    logic                 r_x1_vld;
    t_side                r_x1_side;
    logic signed [2*AW-1:0] r_x1_pz;
    logic signed [2*AW-1:0] r_x1_py;
    logic signed [AW-1:0] w_ux;

    logic                 r_x2_vld;
    t_side                r_x2_side;
    logic signed [VW-1:0] r_x2_c [3];

    logic                 r_y1_vld;
    t_side                r_y1_side;
    logic signed [2*AW-1:0] r_y1_p [6];

    logic                 r_y2_vld;
    t_side                r_y2_side;
    logic signed [VW-1:0] r_y2_c [3];

    logic                 r_z1_vld;
    logic signed [PW-1:0] r_z1_p  [3][3];
    logic signed [AW-1:0] r_z1_ax [3][3];
    logic                 r_z1_ok [3];
    t_side                w_zs;

    logic                 r_z2_vld;
    logic signed [SW-1:0] r_z2_s  [3];
    logic signed [AW-1:0] r_z2_ax [3][3];
    logic                 r_z2_ok [3];

    lavm_pkg::t_row       n_row [3];
    lavm_pkg::t_row       r_out;
    lavm_pkg::t_row       r_q1;
    lavm_pkg::t_row       r_q2;
    logic                 r_ov;
    logic [1:0]           r_cnt;

    assign w_accept = start && !busy;
    assign busy     = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else if (w_accept) begin
            r_gap <= 2'd2;
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    always_comb begin
        if (i_cmd.use_default) begin
            n_eye[0] = '0;
            n_eye[1] = EYE_DEF;
            n_eye[2] = -EYE_DEF;
            n_d[0]   = '0;
            n_d[1]   = -VW'(EYE_DEF);
            n_d[2]   = VW'(EYE_DEF);
        end else begin
            n_eye[0] = EW'(i_cmd.eye_x);
            n_eye[1] = EW'(i_cmd.eye_y);
            n_eye[2] = EW'(i_cmd.eye_z);
            n_d[0]   = VW'(i_cmd.target_x) - VW'(i_cmd.eye_x);
            n_d[1]   = VW'(i_cmd.target_y) - VW'(i_cmd.eye_y);
            n_d[2]   = VW'(i_cmd.target_z) - VW'(i_cmd.eye_z);
        end
    end

    always_comb begin
        w_a_in.vld = r_in_vld;
        w_a_in.x   = r_d[0];
        w_a_in.y   = r_d[1];
        w_a_in.z   = r_d[2];
        w_b_in.vld = r_x2_vld;
        w_b_in.x   = r_x2_c[0];
        w_b_in.y   = r_x2_c[1];
        w_b_in.z   = r_x2_c[2];
        w_c_in.vld = r_y2_vld;
        w_c_in.x   = r_y2_c[0];
        w_c_in.y   = r_y2_c[1];
        w_c_in.z   = r_y2_c[2];
        n_a_side    = '0;
        n_a_side.ex = r_eye[0];
        n_a_side.ey = r_eye[1];
        n_a_side.ez = r_eye[2];
    end

    always_comb begin
        n_x1_side     = r_dla[LAT-1];
        n_x1_side.fx  = w_a_out.x;
        n_x1_side.fy  = w_a_out.y;
        n_x1_side.fz  = w_a_out.z;
        n_x1_side.fok = w_a_out.ok;
        n_y1_side     = r_dlb[LAT-1];
        n_y1_side.rx  = w_b_out.x;
        n_y1_side.ry  = w_b_out.y;
        n_y1_side.rz  = w_b_out.z;
        n_y1_side.rok = w_b_out.ok;
    end

    lavm_unit u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (w_a_in),
        .o_unit  (w_a_out)
    );

    lavm_unit u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (w_b_in),
        .o_unit  (w_b_out)
    );

    lavm_unit u_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (w_c_in),
        .o_unit  (w_c_out)
    );

    assign w_ux = (w_a_out.ok && w_a_out.x == '0 && w_a_out.y == lavm_pkg::ONE
                   && w_a_out.z == '0) ? lavm_pkg::UP_X : '0;
    assign w_zs = r_dlc[LAT-1];

    always_comb begin
        logic                 neg;
        logic [SW-1:0]        mag;
        logic [SW-1:0]        rnd;
        logic signed [31:0]   tr;
        for (int r = 0; r < 3; r++) begin
            neg = r_z2_s[r][SW-1];
            mag = neg ? SW'(-r_z2_s[r]) : SW'(r_z2_s[r]);
            rnd = (mag + (SW'(1) << (FB - 1))) >> FB;
            if (!r_z2_ok[r]) begin
                tr = '0;
            end else if (neg) begin
                tr = (rnd > SW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(rnd);
            end else begin
                tr = (rnd > SW'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(-rnd);
            end
            n_row[r].row_index   = 2'(r);
            n_row[r].axis_x      = 32'(r_z2_ax[r][0]);
            n_row[r].axis_y      = 32'(r_z2_ax[r][1]);
            n_row[r].axis_z      = 32'(r_z2_ax[r][2]);
            n_row[r].translation = tr;
            n_row[r].degenerate  = !r_z2_ok[r];
            n_row[r].last_row    = (2'(r) == lavm_pkg::ROW_FWD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_x1_vld <= 1'b0;
            r_x2_vld <= 1'b0;
            r_y1_vld <= 1'b0;
            r_y2_vld <= 1'b0;
            r_z1_vld <= 1'b0;
            r_z2_vld <= 1'b0;
            r_ov     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_in_vld <= w_accept;
            r_x1_vld <= w_a_out.vld;
            r_x2_vld <= r_x1_vld;
            r_y1_vld <= w_b_out.vld;
            r_y2_vld <= r_y1_vld;
            r_z1_vld <= w_c_out.vld;
            r_z2_vld <= r_z1_vld;
            if (r_z2_vld) begin
                r_ov  <= 1'b1;
                r_cnt <= 2'd2;
            end else if (r_cnt != 2'd0) begin
                r_ov  <= 1'b1;
                r_cnt <= r_cnt - 2'd1;
            end else begin
                r_ov  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eye <= n_eye;
        r_d   <= n_d;

        r_dla[0] <= n_a_side;
        r_dlb[0] <= r_x2_side;
        r_dlc[0] <= r_y2_side;
        for (int k = 1; k < LAT; k++) begin
            r_dla[k] <= r_dla[k-1];
            r_dlb[k] <= r_dlb[k-1];
            r_dlc[k] <= r_dlc[k-1];
        end

        r_x1_side     <= n_x1_side;
        r_x1_pz       <= (2*AW)'(w_ux) * (2*AW)'(w_a_out.z);
        r_x1_py       <= (2*AW)'(w_ux) * (2*AW)'(w_a_out.y);

        r_x2_side <= r_x1_side;
        r_x2_c[0] <= VW'(r_x1_side.fz) <<< FB;
        r_x2_c[1] <= -VW'(r_x1_pz);
        r_x2_c[2] <= VW'(r_x1_py) - (VW'(r_x1_side.fx) <<< FB);

        r_y1_side     <= n_y1_side;
        r_y1_p[0] <= (2*AW)'(r_dlb[LAT-1].fy) * (2*AW)'(w_b_out.z);
        r_y1_p[1] <= (2*AW)'(r_dlb[LAT-1].fz) * (2*AW)'(w_b_out.y);
        r_y1_p[2] <= (2*AW)'(r_dlb[LAT-1].fz) * (2*AW)'(w_b_out.x);
        r_y1_p[3] <= (2*AW)'(r_dlb[LAT-1].fx) * (2*AW)'(w_b_out.z);
        r_y1_p[4] <= (2*AW)'(r_dlb[LAT-1].fx) * (2*AW)'(w_b_out.y);
        r_y1_p[5] <= (2*AW)'(r_dlb[LAT-1].fy) * (2*AW)'(w_b_out.x);

        r_y2_side <= r_y1_side;
        r_y2_c[0] <= VW'(r_y1_p[0]) - VW'(r_y1_p[1]);
        r_y2_c[1] <= VW'(r_y1_p[2]) - VW'(r_y1_p[3]);
        r_y2_c[2] <= VW'(r_y1_p[4]) - VW'(r_y1_p[5]);

        r_z1_ax[0][0] <= w_zs.rx;
        r_z1_ax[0][1] <= w_zs.ry;
        r_z1_ax[0][2] <= w_zs.rz;
        r_z1_ax[1][0] <= w_c_out.x;
        r_z1_ax[1][1] <= w_c_out.y;
        r_z1_ax[1][2] <= w_c_out.z;
        r_z1_ax[2][0] <= w_zs.fx;
        r_z1_ax[2][1] <= w_zs.fy;
        r_z1_ax[2][2] <= w_zs.fz;
        r_z1_ok[0]    <= w_zs.rok;
        r_z1_ok[1]    <= w_c_out.ok;
        r_z1_ok[2]    <= w_zs.fok;
        r_z1_p[0][0]  <= PW'(w_zs.rx) * PW'(w_zs.ex);
        r_z1_p[0][1]  <= PW'(w_zs.ry) * PW'(w_zs.ey);
        r_z1_p[0][2]  <= PW'(w_zs.rz) * PW'(w_zs.ez);
        r_z1_p[1][0]  <= PW'(w_c_out.x) * PW'(w_zs.ex);
        r_z1_p[1][1]  <= PW'(w_c_out.y) * PW'(w_zs.ey);
        r_z1_p[1][2]  <= PW'(w_c_out.z) * PW'(w_zs.ez);
        r_z1_p[2][0]  <= PW'(w_zs.fx) * PW'(w_zs.ex);
        r_z1_p[2][1]  <= PW'(w_zs.fy) * PW'(w_zs.ey);
        r_z1_p[2][2]  <= PW'(w_zs.fz) * PW'(w_zs.ez);

        r_z2_ax <= r_z1_ax;
        r_z2_ok <= r_z1_ok;
        for (int r = 0; r < 3; r++) begin
            r_z2_s[r] <= SW'(r_z1_p[r][0]) + SW'(r_z1_p[r][1]) + SW'(r_z1_p[r][2]);
        end

        if (r_z2_vld) begin
            r_out <= n_row[0];
            r_q1  <= n_row[1];
            r_q2  <= n_row[2];
        end else if (r_cnt != 2'd0) begin
            r_out <= r_q1;
            r_q1  <= r_q2;
        end
    end

    assign o_result_valid = r_ov;
    assign o_result       = r_out;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a transaction");

    a_last_is_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last_row |-> o_result.row_index == lavm_pkg::ROW_FWD)
        else $error("last row flag on wrong row");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.row_index == lavm_pkg::ROW_RIGHT
        |=> o_result_valid && o_result.row_index == lavm_pkg::ROW_UP)
        else $error("rows out of order");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.degenerate |-> o_result.axis_x == '0
        && o_result.axis_y == '0 && o_result.axis_z == '0 && o_result.translation == '0)
        else $error("degenerate row not zero");

    a_fwd_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.row_index == lavm_pkg::ROW_FWD && o_result.degenerate
        |-> $past(o_result.degenerate))
        else $error("zero forward axis with nonzero up axis");

endmodule
